### sv/aoi_pkg.sv
`default_nettype none
package aoi_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicMax   = 24;
  localparam int StepW       = $clog2(CordicMax);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;
  localparam logic [29:0]        InvTwoPi   = 30'd683565276;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] RegMaxSpeed   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxCurv    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTickPeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStraightTh = 3'd4;

  localparam logic [22:0] RstMaxSpeed   = 23'd262144;
  localparam logic [22:0] RstMaxCurv    = 23'd65536;
  localparam logic [22:0] RstMaxStep    = 23'd1311;
  localparam logic [15:0] RstTickPeriod = 16'd1311;
  localparam logic [15:0] RstStraightTh = 16'd66;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [29:0] atan_lookup(input logic [StepW-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [25:0] clamp_sym(input logic signed [25:0] v,
                                                   input logic [22:0] lim);
    logic signed [25:0] l;
    l = signed'({3'b000, lim});
    if (v > l) return l;
    else if (v < -l) return -l;
    else return v;
  endfunction

endpackage
`default_nettype wire

### sv/aoi_if.sv
`default_nettype none
interface aoi_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] cmd_velocity;
  logic signed [23:0] cmd_curvature;
  logic               cmd_fresh;
  modport source (output valid, cmd_velocity, cmd_curvature, cmd_fresh, input ready);
  modport sink   (input valid, cmd_velocity, cmd_curvature, cmd_fresh, output ready);
endinterface

interface aoi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [23:0] speed;
  modport source (output valid, pos_x, pos_y, heading, speed, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, speed, output ready);
endinterface

interface aoi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [22:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ackermann_odometry_integrator_top.sv
// The arc path runs two 36-step divides and two 16-step CORDIC passes; a straight
// tick runs one CORDIC pass (heading) and the shared 33x33 multiplier sequence.
// A new item is taken only once the last is through: input ready only while the
// sequencer is idle; a result still waiting in the output register holds off the next one.
// Reset: asynchronous, active low; pose and speed clear to zero, limits take defaults.
`default_nettype none
module ackermann_odometry_integrator_top import aoi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  aoi_in_if.sink    in_i,
  aoi_out_if.source out_o,
  aoi_cfg_if.sink   cfg_i
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SPD  = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_DIST = 5'd3;
  localparam logic [4:0] ST_M2   = 5'd4;
  localparam logic [4:0] ST_P    = 5'd5;
  localparam logic [4:0] ST_M3   = 5'd6;
  localparam logic [4:0] ST_M4   = 5'd7;
  localparam logic [4:0] ST_TH   = 5'd8;
  localparam logic [4:0] ST_CW   = 5'd9;
  localparam logic [4:0] ST_DV1  = 5'd10;
  localparam logic [4:0] ST_DV2  = 5'd11;
  localparam logic [4:0] ST_HCS  = 5'd12;
  localparam logic [4:0] ST_HCW  = 5'd13;
  localparam logic [4:0] ST_W1   = 5'd14;
  localparam logic [4:0] ST_W2   = 5'd15;
  localparam logic [4:0] ST_W3   = 5'd16;
  localparam logic [4:0] ST_W4   = 5'd17;
  localparam logic [4:0] ST_W5   = 5'd18;
  localparam logic [4:0] ST_W6   = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  logic [4:0] state_q, state_d;

  logic [22:0] max_speed_q, max_curv_q, max_step_q;
  logic [15:0] tick_q, thresh_q;

  logic signed [23:0] vel_q, vel_d, crv_q, crv_d, curv_q, curv_d;
  logic signed [23:0] speed_q, speed_d, dist_q, dist_d;
  logic [46:0]        mag_q, mag_d;
  logic               pneg_q, pneg_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [65:0] prod_q, prod_d, p_abs;
  logic [31:0]        dth_q, dth_d, qv;
  logic signed [31:0] dx_q, dx_d, dy_q, dy_d, x_q, x_d, y_q, y_d;
  logic [15:0]        heading_q, heading_d;
  logic               ovld_q, ovld_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d;
  logic signed [15:0] oh_q, oh_d;
  logic signed [23:0] os_q, os_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [25:0] vel_c, curv_c, dv_c;
  logic [23:0]        acurv;
  logic               straight;

  logic               cor_start, div_start;
  logic [31:0]        cor_angle;
  logic signed [32:0] cor_cos, cor_sin;
  logic signed [35:0] div_num, sin_w, cdiff;
  logic signed [31:0] div_quo;
  unit_stat_t         cor_stat, div_stat;

  aoi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .stat_o  (cor_stat)
  );

  aoi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (curv_q),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign vel_c  = clamp_sym(26'(vel_q), max_speed_q);
  assign curv_c = clamp_sym(26'(crv_q), max_curv_q);
  assign dv_c   = clamp_sym(vel_c - 26'(speed_q), max_step_q);

  assign acurv    = curv_q[23] ? 24'(-curv_q) : 24'(curv_q);
  assign straight = (curv_q == '0) || (acurv < {8'b0, thresh_q});

  assign p_abs = prod_q[65] ? -prod_q : prod_q;
  assign qv    = acc_q[31:0] + prod_q[31:0];
  assign sin_w = 36'(cor_sin);
  assign cdiff = 36'(OneQ30) - 36'(cor_cos);

  // shared multiplier operand select; product is registered and used in the next state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_M1: begin mul_a = 33'(speed_q); mul_b = signed'({17'b0, tick_q}); end
      ST_M2: begin mul_a = 33'(dist_q);  mul_b = 33'(curv_q); end
      ST_M3: begin
        mul_a = signed'({1'b0, mag_q[31:0]});
        mul_b = signed'({3'b000, InvTwoPi});
      end
      ST_M4: begin
        mul_a = signed'({18'b0, mag_q[46:32]});
        mul_b = signed'({3'b000, InvTwoPi});
      end
      ST_W1: begin mul_a = 33'(dx_q); mul_b = cor_cos; end
      ST_W2: begin mul_a = 33'(dy_q); mul_b = cor_sin; end
      ST_W3: begin mul_a = 33'(dx_q); mul_b = cor_sin; end
      ST_W4: begin mul_a = 33'(dy_q); mul_b = cor_cos; end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    vel_d = vel_q; crv_d = crv_q; curv_d = curv_q; speed_d = speed_q;
    dist_d = dist_q; mag_d = mag_q; pneg_d = pneg_q; acc_d = acc_q;
    dth_d = dth_q; dx_d = dx_q; dy_d = dy_q; x_d = x_q; y_d = y_q;
    heading_d = heading_q;
    ovld_d = ovld_q; ox_d = ox_q; oy_d = oy_q; oh_d = oh_q; os_d = os_q;
    cor_start = 1'b0; cor_angle = {heading_q, 16'b0};
    div_start = 1'b0; div_num = sin_w <<< 2;

    if (ovld_q && out_o.ready) ovld_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          vel_d   = in_i.cmd_fresh ? in_i.cmd_velocity : '0;
          crv_d   = in_i.cmd_curvature;
          state_d = ST_SPD;
        end
      end
      ST_SPD: begin
        speed_d = speed_q + dv_c[23:0];
        curv_d  = curv_c[23:0];
        state_d = ST_M1;
      end
      ST_M1: state_d = ST_DIST;
      ST_DIST: begin
        dist_d = prod_q[39:16];
        if (straight) begin
          dx_d    = 32'(signed'(prod_q[39:16]));
          dy_d    = '0;
          dth_d   = '0;
          state_d = ST_HCS;
        end else begin
          state_d = ST_M2;
        end
      end
      ST_M2: state_d = ST_P;
      ST_P: begin
        pneg_d  = prod_q[65];
        mag_d   = p_abs[46:0];
        state_d = ST_M3;
      end
      ST_M3: state_d = ST_M4;
      ST_M4: begin
        acc_d   = 64'(prod_q[63:32]);
        state_d = ST_TH;
      end
      ST_TH: begin
        dth_d     = pneg_q ? -qv : qv;
        cor_angle = pneg_q ? -qv : qv;
        cor_start = 1'b1;
        state_d   = ST_CW;
      end
      ST_CW: begin
        if (cor_stat.done) begin
          div_num   = sin_w <<< 2;
          div_start = 1'b1;
          state_d   = ST_DV1;
        end
      end
      ST_DV1: begin
        if (div_stat.done) begin
          dx_d      = div_quo;
          div_num   = cdiff <<< 2;
          div_start = 1'b1;
          state_d   = ST_DV2;
        end
      end
      ST_DV2: begin
        if (div_stat.done) begin
          dy_d    = div_quo;
          state_d = ST_HCS;
        end
      end
      ST_HCS: begin
        cor_start = 1'b1;
        state_d   = ST_HCW;
      end
      ST_HCW: if (cor_stat.done) state_d = ST_W1;
      ST_W1: state_d = ST_W2;
      ST_W2: begin
        acc_d   = prod_q[63:0];
        state_d = ST_W3;
      end
      ST_W3: begin
        acc_d   = acc_q - prod_q[63:0];
        state_d = ST_W4;
      end
      ST_W4: begin
        x_d     = x_q + acc_q[61:30];
        acc_d   = prod_q[63:0];
        state_d = ST_W5;
      end
      ST_W5: begin
        acc_d   = acc_q + prod_q[63:0];
        state_d = ST_W6;
      end
      ST_W6: begin
        y_d       = y_q + acc_q[61:30];
        heading_d = heading_q + dth_q[31:16] + {15'b0, dth_q[15]};
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          ox_d    = x_q;
          oy_d    = y_q;
          oh_d    = signed'(heading_q);
          os_d    = speed_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_speed_q <= RstMaxSpeed;
      max_curv_q  <= RstMaxCurv;
      max_step_q  <= RstMaxStep;
      tick_q      <= RstTickPeriod;
      thresh_q    <= RstStraightTh;
      speed_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      heading_q   <= '0;
      ovld_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      speed_q   <= speed_d;
      x_q       <= x_d;
      y_q       <= y_d;
      heading_q <= heading_d;
      ovld_q    <= ovld_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          RegMaxSpeed:   max_speed_q <= cfg_i.data;
          RegMaxCurv:    max_curv_q  <= cfg_i.data;
          RegMaxStep:    max_step_q  <= cfg_i.data;
          RegTickPeriod: tick_q      <= cfg_i.data[15:0];
          RegStraightTh: thresh_q    <= cfg_i.data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vel_q  <= vel_d;
    crv_q  <= crv_d;
    curv_q <= curv_d;
    dist_q <= dist_d;
    mag_q  <= mag_d;
    pneg_q <= pneg_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    dth_q  <= dth_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oh_q   <= oh_d;
    os_q   <= os_d;
  end

  assign out_o.valid   = ovld_q;
  assign out_o.pos_x   = ox_q;
  assign out_o.pos_y   = oy_q;
  assign out_o.heading = oh_q;
  assign out_o.speed   = os_q;

  a_cor_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_start |-> !cor_stat.busy) else $error("cordic started while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider started while busy");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_SPD))
    else $error("accepted item did not start the sequence");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !ovld_q) |=> (ovld_q && state_q == ST_IDLE))
    else $error("result not loaded into output register");

endmodule
`default_nettype wire

### sv/aoi_cordic.sv
`default_nettype none
module aoi_cordic import aoi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o,
  output unit_stat_t         stat_o
);

  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] x_d, y_d, z_d;
  logic               flip_q, flip_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic               flip_c;
  logic [31:0]        ang_c;
  logic signed [33:0] xs, ys, at;

  // quadrants 1 and 2 are turned by pi, result negated at the end
  assign flip_c = angle_i[31] ^ angle_i[30];
  assign ang_c  = angle_i + {flip_c, 31'b0};
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign at     = signed'({4'b0000, atan_lookup(cnt_q)});

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q;
    flip_d = flip_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d    = CordicGain;
      y_d    = '0;
      z_d    = 34'(signed'(ang_c));
      flip_d = flip_c;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign cos_o       = flip_q ? -x_q[32:0] : x_q[32:0];
  assign sin_o       = flip_q ? -y_q[32:0] : y_q[32:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

### sv/aoi_div.sv
`default_nettype none
module aoi_div import aoi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [35:0] num_i,
  input  logic signed [23:0] den_i,
  output logic signed [31:0] quo_o,
  output unit_stat_t         stat_o
);

  logic [35:0] n_q, n_d, q_q, q_d;
  logic [22:0] d_q, d_d;
  logic [23:0] rem_q, rem_d, trial;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [35:0] num_abs;
  logic [23:0] den_abs;
  logic [31:0] sat;

  assign num_abs = num_i[35] ? 36'(-num_i) : 36'(num_i);
  assign den_abs = den_i[23] ? 24'(-den_i) : 24'(den_i);
  assign trial   = {rem_q[22:0], n_q[35]};

  always_comb begin
    n_d = n_q; q_d = q_q; d_d = d_q; rem_d = rem_q;
    neg_d = neg_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      n_d    = num_abs;
      d_d    = den_abs[22:0];
      q_d    = '0;
      rem_d  = '0;
      neg_d  = num_i[35] ^ den_i[23];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[34:0], 1'b0};
      if (trial >= {1'b0, d_q}) begin
        rem_d = trial - {1'b0, d_q};
        q_d   = {q_q[34:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d   = {q_q[34:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'd35) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    q_q   <= q_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // saturate magnitude to 2^31-1, then apply sign (truncating division)
  assign sat         = (|q_q[35:31]) ? 32'h7FFF_FFFF : {1'b0, q_q[30:0]};
  assign quo_o       = neg_q ? -signed'(sat) : signed'(sat);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

### dv/tb_ackermann_odometry_integrator_top.sv
`default_nettype none
module tb_ackermann_odometry_integrator_top;
  import aoi_pkg::*;

  logic clk_i;
  logic rst_ni;
  bit   calm;   // no idling on either side while set

  aoi_in_if  in_if ();
  aoi_out_if out_if ();
  aoi_cfg_if cfg_if ();

  ackermann_odometry_integrator_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hd;
    logic signed [23:0] spd;
  } pose_t;

  class odom_scoreboard;
    longint lim_speed, lim_curv, lim_step, tick, thresh;
    longint spd;
    logic [31:0] px, py;
    logic [15:0] hd;
    pose_t expected_poses[$];
    int    errors;
    int    seen;
    int    arcs;
    longint atan_q30[24];

    function new();
      atan_q30 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
      lim_speed = RstMaxSpeed;
      lim_curv  = RstMaxCurv;
      lim_step  = RstMaxStep;
      tick      = RstTickPeriod;
      thresh    = RstStraightTh;
      spd = 0;
      px  = '0;
      py  = '0;
      hd  = '0;
      errors = 0;
      seen   = 0;
      arcs   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegMaxSpeed:   lim_speed = d;
        RegMaxCurv:    lim_curv  = d;
        RegMaxStep:    lim_step  = d;
        RegTickPeriod: tick      = d[15:0];
        RegStraightTh: thresh    = d[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint l);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
    endfunction

    // rotation-mode CORDIC, Q30; angle is a 32 bit binary angle
    function void rotate(logic [31:0] ang, output longint c, output longint s);
      logic   flip;
      longint x, y, z, nx, ny;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= atan_q30[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += atan_q30[i];
        end
        x = nx;
        y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void predict_pose(logic signed [23:0] v_in, logic signed [23:0] k_in,
                               logic fresh);
      longint vel, curv, travel, dx, dy, ch, sh, c, s, p;
      longint unsigned mag, qv;
      logic [31:0] dth;
      pose_t e;
      vel  = fresh ? longint'(v_in) : 0;
      curv = clip(longint'(k_in), lim_curv);
      dth  = '0;
      vel  = clip(vel, lim_speed);
      spd  = spd + clip(vel - spd, lim_step);
      travel = (spd * tick) >>> 16;
      if (curv == 0 || (curv < 0 ? -curv : curv) < thresh) begin
        dx = travel;
        dy = 0;
      end else begin
        arcs++;
        p   = travel * curv;
        mag = p < 0 ? -p : p;
        qv  = (((mag & 64'hFFFF_FFFF) * 64'd683565276) >> 32) + (mag >> 32) * 64'd683565276;
        if (p < 0) qv = 64'd0 - qv;
        dth = qv[31:0];
        rotate(dth, c, s);
        dx = clip((s * 4) / curv, 64'sd2147483647);
        dy = clip(((64'sd1073741824 - c) * 4) / curv, 64'sd2147483647);
      end
      rotate({hd, 16'h0000}, ch, sh);
      px = px + 32'((dx * ch - dy * sh) >>> 30);
      py = py + 32'((dx * sh + dy * ch) >>> 30);
      qv = ({32'd0, dth} + 64'h8000) >> 16;
      hd = hd + qv[15:0];
      e.x   = px;
      e.y   = py;
      e.hd  = hd;
      e.spd = spd[23:0];
      expected_poses.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, seen);
    endtask

    task check_pose(pose_t got);
      pose_t e;
      seen++;
      if (expected_poses.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = expected_poses.pop_front();
      if (got.x !== e.x) report("pos_x", got.x, e.x);
      if (got.y !== e.y) report("pos_y", got.y, e.y);
      if (got.hd !== e.hd) report("heading", got.hd, e.hd);
      if (got.spd !== e.spd) report("speed", got.spd, e.spd);
    endtask
  endclass

  odom_scoreboard sb;
  int sent;
  int cfg_writes;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random backpressure
  int hold;
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    int n;
    pose_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.x   = out_if.pos_x;
        got.y   = out_if.pos_y;
        got.hd  = out_if.heading;
        got.spd = out_if.speed;
        sb.check_pose(got);
        n = gap_len();
        if (n > 0) begin
          hold <= n - 1;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(logic signed [23:0] v, logic signed [23:0] k, logic fresh);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd_velocity  <= v;
    in_if.cmd_curvature <= k;
    in_if.cmd_fresh     <= fresh;
    do @(posedge clk_i); while (!in_if.ready);
    sb.predict_pose(v, k, fresh);
    sent++;
  endtask

  // block must be idle: all results back, then the longest tick latency
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_poses.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, d);
    cfg_writes++;
  endtask

  task automatic set_limits(logic [22:0] ms, logic [22:0] mc, logic [22:0] st,
                            logic [22:0] tp, logic [22:0] th);
    write_reg(RegMaxSpeed, ms);
    write_reg(RegMaxCurv, mc);
    write_reg(RegMaxStep, st);
    write_reg(RegTickPeriod, tp);
    write_reg(RegStraightTh, th);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_cmds(int n);
    logic signed [23:0] v, k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) v = 24'($urandom);
      else v = 24'(int'($urandom_range(0, 2 * sb.lim_speed + 200)) - sb.lim_speed - 100);
      r = $urandom_range(0, 9);
      if (r < 2) k = 24'($urandom);
      else if (r < 3) k = 0;
      else if (r < 5) k = 24'(int'($urandom_range(0, 2 * sb.thresh + 4)) - sb.thresh - 2);
      else k = 24'(int'($urandom_range(0, 2 * sb.lim_curv + 200)) - sb.lim_curv - 100);
      send_cmd(v, k, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    cfg_writes = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd_velocity = '0;
    in_if.cmd_curvature = '0;
    in_if.cmd_fresh = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, then wide-open limits, then zero limits
    send_cmd(24'sh7FFFFF, 24'sd0, 1'b1);
    send_cmd(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    send_cmd(-24'sh800000, -24'sh800000, 1'b1);
    send_cmd(24'sd100000, 24'sd65, 1'b1);
    send_cmd(24'sd100000, 24'sd66, 1'b1);
    send_cmd(24'sd100000, -24'sd66, 1'b1);
    send_cmd(24'sd100000, 24'sd30000, 1'b0);   // stale: curvature still used
    send_cmd(24'sd0, 24'sd0, 1'b0);
    drain();
    set_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'hFFFF, 23'd0);
    send_cmd(24'sh7FFFFF, 24'sd1, 1'b1);
    send_cmd(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    send_cmd(-24'sh800000, -24'sh800000, 1'b1);
    send_cmd(24'sh7FFFFF, 24'sd0, 1'b1);
    send_cmd(24'sh7FFFFF, -24'sd3, 1'b0);
    send_cmd(-24'sd5, 24'sd123456, 1'b1);
    drain();
    set_limits(23'd0, 23'd0, 23'd0, 23'd1, 23'hFFFF);
    send_cmd(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    send_cmd(-24'sh800000, 24'sd1000, 1'b1);
    drain();
    // unused indexes and bits above the 16 bit registers
    write_reg(RegStraightTh + 3'd1, 23'h7FFFFF);
    write_reg(3'd7, 23'h123);
    write_reg(RegTickPeriod, 23'h7F0520);
    write_reg(RegStraightTh, 23'h7F0040);
    cfg_if.valid <= 1'b0;
    send_cmd(24'sd0, 24'sd0, 1'b1);

    // random phases through several limit settings
    drain();
    set_limits(RstMaxSpeed, RstMaxCurv, RstMaxStep, RstTickPeriod, RstStraightTh);
    random_cmds(120);
    drain();
    calm = 1'b1;
    set_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'hFFFF, 23'd0);
    random_cmds(80);
    drain();
    calm = 1'b0;
    set_limits(23'd400000, 23'd200000, 23'd20000, 23'd6554, 23'd500);
    random_cmds(120);
    drain();
    set_limits(23'd0, 23'd0, 23'd0, 23'd1, 23'hFFFF);
    random_cmds(30);
    drain();
    set_limits(23'd3000000, 23'd1000, 23'd500000, 23'd30000, 23'd10);
    random_cmds(100);
    drain();
    set_limits(23'($urandom), 23'($urandom), 23'($urandom),
               23'($urandom_range(1, 65535)), 23'($urandom_range(0, 65535)));
    random_cmds(100);

    drain();
    $display("%0d command items over directed and random limit settings, %0d arc ticks, %0d register writes",
             sent, sb.arcs, cfg_writes);
    $display("%0d results checked, %0d mismatches", sb.seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
